[sv/i2c_master_byte_engine_macros.svh]
// assertion macros for the i2c master byte engine
// used by the top level only, no dependencies
`ifndef I2C_MASTER_BYTE_ENGINE_MACROS_SVH
`define I2C_MASTER_BYTE_ENGINE_MACROS_SVH

// same-cycle implication, disabled in reset
`define I2CM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled in reset
`define I2CM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/i2cm_pkg.sv]
// shared types and constants for the i2c master byte engine
// no dependencies
package i2cm_pkg;

   localparam int BITS_PER_BYTE = 8;
   localparam int BIT_CNT_W     = $clog2(BITS_PER_BYTE + 1);
   localparam int DELAY_W       = 10;

   localparam logic [7:0] TICKS_PER_US_RESET   = 8'd8;
   localparam logic [7:0] ACK_POLL_LIMIT_RESET = 8'd250;

   typedef enum logic [2:0] {
      REQ_NONE     = 3'd0,
      REQ_START    = 3'd1,
      REQ_STOP     = 3'd2,
      REQ_WRITE    = 3'd3,
      REQ_READ     = 3'd4,
      REQ_WAIT_ACK = 3'd5
   } req_code_type;

   typedef enum logic [0:0] {
      CSR_TICKS_PER_US   = 1'b0,
      CSR_ACK_POLL_LIMIT = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'd0,
      PH_ST_A    = 4'd1,
      PH_ST_B    = 4'd2,
      PH_SP_A    = 4'd3,
      PH_SP_B    = 4'd4,
      PH_WA_A    = 4'd5,
      PH_WA_B    = 4'd6,
      PH_WA_POLL = 4'd7,
      PH_WR_D    = 4'd8,
      PH_WR_H    = 4'd9,
      PH_WR_L    = 4'd10,
      PH_RD_L    = 4'd11,
      PH_RD_H    = 4'd12,
      PH_AK_D    = 4'd13,
      PH_AK_H    = 4'd14
   } phase_type;

   typedef struct packed {
      logic [7:0] ticks_per_us;
      logic [7:0] ack_poll_limit;
   } cfg_type;

   // request tdata, lowest bit last
   typedef struct packed {
      logic [5:0] pad;
      logic       sda_in;
      logic       send_ack;
      logic [7:0] tx_byte;
   } req_data_type;

   // result tdata, lowest bit last
   typedef struct packed {
      logic [1:0] pad;
      logic       ack_failed;
      logic [7:0] rx_byte;
      logic       done_res;
      logic       busy_res;
      logic       sda_oe;
      logic       sda_out;
      logic       scl;
   } rsp_data_type;

   // events decided by the phase logic for one tick
   typedef struct packed {
      logic enter;
      logic count_dec;
      logic finish;
      logic scl_low;
      logic rx_load;
      logic load_write;
      logic load_read;
      logic bit_inc;
      logic poll_clr;
      logic poll_inc;
      logic fail_clr;
      logic fail_set;
   } event_type;

endpackage

[sv/i2cm_csr.sv]
// configuration registers of the i2c master byte engine
// depends on i2cm_pkg
module i2cm_csr
   import i2cm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [7:0]    csr_wdata,
   output cfg_type       cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TICKS_PER_US:   cfg_in.ticks_per_us   = csr_wdata;
            CSR_ACK_POLL_LIMIT: cfg_in.ack_poll_limit = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ticks_per_us   <= TICKS_PER_US_RESET;
         cfg_ff.ack_poll_limit <= ACK_POLL_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[sv/i2cm_seq.sv]
// pin sequencer: phase state, hold counter, shifter and status for one tick per item
// depends on i2cm_pkg
module i2cm_seq
   import i2cm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step,
   input  logic [2:0]   req_code,
   input  req_data_type req_data,
   input  cfg_type      cfg,
   output rsp_data_type rsp_next
);

   phase_type              phase_ff, phase_in;
   logic [DELAY_W-1:0]     delay_ff, delay_in;
   logic [BIT_CNT_W-1:0]   bit_ff, bit_in, bit_next;
   logic [7:0]             shift_ff, shift_in, shift_base;
   logic [7:0]             poll_ff, poll_in;
   logic                   ack_ff, ack_in, ack_base;
   logic                   scl_ff, scl_in;
   logic                   sda_ff, sda_in_lvl;
   logic                   oe_ff, oe_in;
   logic                   fail_ff, fail_in;
   logic [7:0]             rx_ff, rx_in;
   logic                   do_poll;
   logic [DELAY_W-1:0]     hold1, hold2, hold4;
   event_type              ev;

   assign bit_next = bit_ff + BIT_CNT_W'(1);
   assign do_poll  = (phase_ff == PH_WA_POLL) ||
                     ((phase_ff == PH_WA_B) && (delay_ff <= DELAY_W'(1)));
   assign hold1    = {2'b00, cfg.ticks_per_us};
   assign hold2    = {1'b0, cfg.ticks_per_us, 1'b0};
   assign hold4    = {cfg.ticks_per_us, 2'b00};

   // next phase and events
   always_comb begin
      phase_in = phase_ff;
      ev       = '0;
      if (step) begin
         if (phase_ff == PH_IDLE) begin
            case (req_code_type'(req_code))
               REQ_START: begin
                  phase_in = PH_ST_A;
                  ev.enter = 1'b1;
               end
               REQ_STOP: begin
                  phase_in = PH_SP_A;
                  ev.enter = 1'b1;
               end
               REQ_WRITE: begin
                  phase_in      = PH_WR_D;
                  ev.enter      = 1'b1;
                  ev.load_write = 1'b1;
               end
               REQ_READ: begin
                  phase_in     = PH_RD_L;
                  ev.enter     = 1'b1;
                  ev.load_read = 1'b1;
               end
               REQ_WAIT_ACK: begin
                  phase_in    = PH_WA_A;
                  ev.enter    = 1'b1;
                  ev.poll_clr = 1'b1;
                  ev.fail_clr = 1'b1;
               end
               default: phase_in = PH_IDLE;
            endcase
         end else if (do_poll) begin
            if (!req_data.sda_in) begin
               phase_in   = PH_IDLE;
               ev.finish  = 1'b1;
               ev.scl_low = 1'b1;
            end else if (poll_ff >= cfg.ack_poll_limit) begin
               phase_in    = PH_SP_A;
               ev.enter    = 1'b1;
               ev.fail_set = 1'b1;
            end else begin
               phase_in    = PH_WA_POLL;
               ev.poll_inc = 1'b1;
            end
         end else if (delay_ff > DELAY_W'(1)) begin
            ev.count_dec = 1'b1;
         end else begin
            case (phase_ff)
               PH_ST_A: begin
                  phase_in = PH_ST_B;
                  ev.enter = 1'b1;
               end
               PH_ST_B: begin
                  phase_in   = PH_IDLE;
                  ev.finish  = 1'b1;
                  ev.scl_low = 1'b1;
               end
               PH_SP_A: begin
                  phase_in = PH_SP_B;
                  ev.enter = 1'b1;
               end
               PH_SP_B: begin
                  phase_in  = PH_IDLE;
                  ev.finish = 1'b1;
               end
               PH_WA_A: begin
                  phase_in = PH_WA_B;
                  ev.enter = 1'b1;
               end
               PH_WR_D: begin
                  phase_in = PH_WR_H;
                  ev.enter = 1'b1;
               end
               PH_WR_H: begin
                  phase_in = PH_WR_L;
                  ev.enter = 1'b1;
               end
               PH_WR_L: begin
                  ev.bit_inc = 1'b1;
                  if (bit_next < BIT_CNT_W'(BITS_PER_BYTE)) begin
                     phase_in = PH_WR_D;
                     ev.enter = 1'b1;
                  end else begin
                     phase_in  = PH_IDLE;
                     ev.finish = 1'b1;
                  end
               end
               PH_RD_L: begin
                  phase_in = PH_RD_H;
                  ev.enter = 1'b1;
               end
               PH_RD_H: begin
                  ev.bit_inc = 1'b1;
                  ev.enter   = 1'b1;
                  if (bit_next < BIT_CNT_W'(BITS_PER_BYTE)) begin
                     phase_in = PH_RD_L;
                  end else begin
                     phase_in = PH_AK_D;
                  end
               end
               PH_AK_D: begin
                  phase_in = PH_AK_H;
                  ev.enter = 1'b1;
               end
               PH_AK_H: begin
                  phase_in   = PH_IDLE;
                  ev.finish  = 1'b1;
                  ev.scl_low = 1'b1;
                  ev.rx_load = 1'b1;
               end
               default: phase_in = PH_IDLE;
            endcase
         end
      end
   end

   // pin levels, counters and data for the phase being entered
   always_comb begin
      delay_in   = delay_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      poll_in    = poll_ff;
      ack_in     = ack_ff;
      scl_in     = scl_ff;
      sda_in_lvl = sda_ff;
      oe_in      = oe_ff;
      fail_in    = fail_ff;
      rx_in      = rx_ff;

      shift_base = ev.load_write ? req_data.tx_byte :
                   ev.load_read  ? 8'h00 : shift_ff;
      ack_base   = ev.load_read ? req_data.send_ack : ack_ff;

      if (ev.load_write || ev.load_read) begin
         bit_in   = '0;
         shift_in = shift_base;
      end
      if (ev.load_read)  ack_in  = ack_base;
      if (ev.bit_inc)    bit_in  = bit_next;
      if (ev.poll_clr)   poll_in = 8'h00;
      if (ev.poll_inc)   poll_in = poll_ff + 8'd1;
      if (ev.fail_clr)   fail_in = 1'b0;
      if (ev.fail_set)   fail_in = 1'b1;
      if (ev.count_dec)  delay_in = delay_ff - DELAY_W'(1);
      if (ev.scl_low)    scl_in  = 1'b0;
      if (ev.rx_load)    rx_in   = shift_ff;

      if (ev.enter) begin
         case (phase_in)
            PH_ST_A: begin
               oe_in = 1'b1; sda_in_lvl = 1'b1; scl_in = 1'b1; delay_in = hold4;
            end
            PH_ST_B: begin
               sda_in_lvl = 1'b0; delay_in = hold4;
            end
            PH_SP_A: begin
               oe_in = 1'b1; scl_in = 1'b0; sda_in_lvl = 1'b0; delay_in = hold4;
            end
            PH_SP_B: begin
               scl_in = 1'b1; sda_in_lvl = 1'b1; delay_in = hold4;
            end
            PH_WA_A: begin
               oe_in = 1'b0; sda_in_lvl = 1'b1; delay_in = hold1;
            end
            PH_WA_B: begin
               scl_in = 1'b1; delay_in = hold1;
            end
            PH_WR_D: begin
               oe_in      = 1'b1;
               scl_in     = 1'b0;
               sda_in_lvl = shift_base[7];
               shift_in   = {shift_base[6:0], 1'b0};
               delay_in   = hold2;
            end
            PH_WR_H: begin
               scl_in = 1'b1; delay_in = hold2;
            end
            PH_WR_L: begin
               scl_in = 1'b0; delay_in = hold2;
            end
            PH_RD_L: begin
               oe_in = 1'b0; scl_in = 1'b0; delay_in = hold2;
            end
            PH_RD_H: begin
               scl_in   = 1'b1;
               shift_in = {shift_base[6:0], req_data.sda_in};
               delay_in = hold1;
            end
            PH_AK_D: begin
               scl_in = 1'b0; oe_in = 1'b1; sda_in_lvl = !ack_base; delay_in = hold2;
            end
            PH_AK_H: begin
               scl_in = 1'b1; delay_in = hold2;
            end
            default: delay_in = delay_ff;
         endcase
      end
   end

   always_comb begin
      rsp_next            = '0;
      rsp_next.scl        = scl_in;
      rsp_next.sda_out    = sda_in_lvl;
      rsp_next.sda_oe     = oe_in;
      rsp_next.busy_res   = (phase_in != PH_IDLE);
      rsp_next.done_res   = ev.finish;
      rsp_next.rx_byte    = rx_in;
      rsp_next.ack_failed = fail_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         delay_ff <= '0;
         bit_ff   <= '0;
         shift_ff <= 8'h00;
         poll_ff  <= 8'h00;
         ack_ff   <= 1'b0;
         scl_ff   <= 1'b1;
         sda_ff   <= 1'b1;
         oe_ff    <= 1'b0;
         fail_ff  <= 1'b0;
         rx_ff    <= 8'h00;
      end else begin
         phase_ff <= phase_in;
         delay_ff <= delay_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         poll_ff  <= poll_in;
         ack_ff   <= ack_in;
         scl_ff   <= scl_in;
         sda_ff   <= sda_in_lvl;
         oe_ff    <= oe_in;
         fail_ff  <= fail_in;
         rx_ff    <= rx_in;
      end
   end

endmodule

[sv/i2cm_out_reg.sv]
// result register on the rsp side, refilled in the cycle it drains
// depends on i2cm_pkg
module i2cm_out_reg
   import i2cm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_data_type load_data,
   output logic         room,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output rsp_data_type rsp_data
);

   logic         valid_ff, valid_in;
   rsp_data_type data_ff, data_in;

   assign room       = !valid_ff || rsp_tready;
   assign valid_in   = load || (valid_ff && !rsp_tready);
   assign data_in    = load ? load_data : data_ff;
   assign rsp_tvalid = valid_ff;
   assign rsp_data   = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

[sv/i2c_master_byte_engine.sv]
// i2c master byte engine: one item per clock tick of pin sequencing
// the result of an item is on rsp in the cycle after it is accepted
// throughput: one item per cycle while the single result register has room; a stalled result stalls req
// reset: synchronous, active high; pins idle with scl high, sda released
// depends on i2cm_pkg, i2cm_csr, i2cm_seq, i2cm_out_reg and the macros header
`include "i2c_master_byte_engine_macros.svh"

module i2c_master_byte_engine
   import i2cm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // tx_byte[7:0], send_ack, sda_in, zero pad
   input  logic [2:0]  req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // scl, sda_out, sda_oe, busy_res, done_res,
                                    // rx_byte[7:0], ack_failed, zero pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   cfg_type      cfg;
   rsp_data_type rsp_next;
   rsp_data_type rsp_data;
   logic         room;
   logic         step;

   assign req_tready = room;
   assign step       = req_tvalid && room;
   assign rsp_tdata  = rsp_data;

   i2cm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index_type'(csr_index)),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   i2cm_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .req_code (req_tuser),
      .req_data (req_data_type'(req_tdata)),
      .cfg      (cfg),
      .rsp_next (rsp_next)
   );

   i2cm_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (step),
      .load_data  (rsp_next),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data)
   );

   `I2CM_ASSERT_NXT(a_item_gives_result, clock, reset,
      req_tvalid && req_tready, rsp_tvalid, "accepted item gave no result")
   `I2CM_ASSERT_IMP(a_stall_blocks_input, clock, reset,
      rsp_tvalid && !rsp_tready, !req_tready, "input taken while result stalled")
   `I2CM_ASSERT_IMP(a_done_not_busy, clock, reset,
      rsp_tvalid && rsp_data.done_res, !rsp_data.busy_res, "done and busy together")

endmodule

[tb/sv/tb_i2c_master_byte_engine.sv]
// self-checking testbench for the i2c master byte engine: one tick per item,
// every result checked against an in-bench prediction of pins and status
// depends on i2cm_pkg and the i2c_master_byte_engine top level
module tb_i2c_master_byte_engine;
   import i2cm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] REQ_SPARE_A = 3'd6;
   localparam logic [2:0] REQ_SPARE_B = 3'd7;

   typedef enum int {SDA_LOW, SDA_HIGH, SDA_RANDOM, SDA_LATE_LOW} sda_plan_type;

   typedef struct packed {
      logic [2:0]   kind;
      req_data_type data;
   } req_tick_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [7:0]  csr_wdata = '0;

   i2c_master_byte_engine u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // engine state as predicted
   phase_type  st_phase;
   logic [9:0] st_delay;
   logic [3:0] st_bit;
   logic [7:0] st_shift, st_polls, st_rx;
   logic       st_ack, st_scl, st_sda, st_oe, st_fail, st_done;
   logic [7:0] cfg_tpu, cfg_limit;

   req_tick_type tick_q [$];
   rsp_data_type pin_expect_q [$];
   event         tick_taken;
   logic         req_fired = 1'b0;
   int unsigned  fail_count = 0;
   int unsigned  results_seen = 0;
   int unsigned  items_sent = 0;
   int unsigned  cmds_issued = 0;
   int unsigned  ack_timeouts = 0;
   int unsigned  kind_seen [8];

   function automatic void i2c_reset_state();
      st_phase  = PH_IDLE;
      st_delay  = '0;
      st_bit    = '0;
      st_shift  = '0;
      st_polls  = '0;
      st_rx     = '0;
      st_ack    = 1'b0;
      st_scl    = 1'b1;
      st_sda    = 1'b1;
      st_oe     = 1'b0;
      st_fail   = 1'b0;
      st_done   = 1'b0;
      cfg_tpu   = TICKS_PER_US_RESET;
      cfg_limit = ACK_POLL_LIMIT_RESET;
   endfunction

   function automatic void load_hold(int units);
      st_delay = 10'(units * int'(cfg_tpu));
   endfunction

   function automatic void finish_seq();
      st_phase = PH_IDLE;
      st_done  = 1'b1;
   endfunction

   function automatic void i2c_enter_phase(phase_type p, logic sda);
      st_phase = p;
      case (p)
         PH_ST_A: begin
            st_oe = 1'b1; st_sda = 1'b1; st_scl = 1'b1; load_hold(4);
         end
         PH_ST_B: begin
            st_sda = 1'b0; load_hold(4);
         end
         PH_SP_A: begin
            st_oe = 1'b1; st_scl = 1'b0; st_sda = 1'b0; load_hold(4);
         end
         PH_SP_B: begin
            st_scl = 1'b1; st_sda = 1'b1; load_hold(4);
         end
         PH_WA_A: begin
            st_oe = 1'b0; st_sda = 1'b1; load_hold(1);
         end
         PH_WA_B: begin
            st_scl = 1'b1; load_hold(1);
         end
         PH_WR_D: begin
            st_oe    = 1'b1;
            st_scl   = 1'b0;
            st_sda   = st_shift[7];
            st_shift = {st_shift[6:0], 1'b0};
            load_hold(2);
         end
         PH_WR_H: begin
            st_scl = 1'b1; load_hold(2);
         end
         PH_WR_L: begin
            st_scl = 1'b0; load_hold(2);
         end
         PH_RD_L: begin
            st_oe = 1'b0; st_scl = 1'b0; load_hold(2);
         end
         PH_RD_H: begin
            st_scl   = 1'b1;
            st_shift = {st_shift[6:0], sda};
            load_hold(1);
         end
         PH_AK_D: begin
            st_scl = 1'b0; st_oe = 1'b1; st_sda = !st_ack; load_hold(2);
         end
         PH_AK_H: begin
            st_scl = 1'b1; load_hold(2);
         end
         default: st_phase = PH_IDLE;
      endcase
   endfunction

   function automatic void i2c_poll_sda(logic sda);
      st_phase = PH_WA_POLL;
      if (!sda) begin
         st_scl = 1'b0;
         finish_seq();
      end else if (st_polls >= cfg_limit) begin
         st_fail = 1'b1;
         ack_timeouts++;
         i2c_enter_phase(PH_SP_A, sda);
      end else begin
         st_polls = st_polls + 8'd1;
      end
   endfunction

   function automatic void i2c_advance_phase(logic sda);
      case (st_phase)
         PH_ST_A: i2c_enter_phase(PH_ST_B, sda);
         PH_ST_B: begin
            st_scl = 1'b0;
            finish_seq();
         end
         PH_SP_A: i2c_enter_phase(PH_SP_B, sda);
         PH_SP_B: finish_seq();
         PH_WA_A: i2c_enter_phase(PH_WA_B, sda);
         PH_WA_B: i2c_poll_sda(sda);
         PH_WR_D: i2c_enter_phase(PH_WR_H, sda);
         PH_WR_H: i2c_enter_phase(PH_WR_L, sda);
         PH_WR_L: begin
            st_bit = st_bit + 4'd1;
            if (st_bit < 4'(BITS_PER_BYTE)) i2c_enter_phase(PH_WR_D, sda);
            else finish_seq();
         end
         PH_RD_L: i2c_enter_phase(PH_RD_H, sda);
         PH_RD_H: begin
            st_bit = st_bit + 4'd1;
            if (st_bit < 4'(BITS_PER_BYTE)) i2c_enter_phase(PH_RD_L, sda);
            else i2c_enter_phase(PH_AK_D, sda);
         end
         PH_AK_D: i2c_enter_phase(PH_AK_H, sda);
         PH_AK_H: begin
            st_scl = 1'b0;
            st_rx  = st_shift;
            finish_seq();
         end
         default: st_phase = PH_IDLE;
      endcase
   endfunction

   function automatic rsp_data_type i2c_tick(logic [2:0] kind, req_data_type d);
      rsp_data_type r;
      st_done = 1'b0;
      if (st_phase == PH_IDLE) begin
         case (kind)
            REQ_START: i2c_enter_phase(PH_ST_A, d.sda_in);
            REQ_STOP:  i2c_enter_phase(PH_SP_A, d.sda_in);
            REQ_WRITE: begin
               st_shift = d.tx_byte;
               st_bit   = '0;
               i2c_enter_phase(PH_WR_D, d.sda_in);
            end
            REQ_READ: begin
               st_ack   = d.send_ack;
               st_shift = '0;
               st_bit   = '0;
               i2c_enter_phase(PH_RD_L, d.sda_in);
            end
            REQ_WAIT_ACK: begin
               st_fail  = 1'b0;
               st_polls = '0;
               i2c_enter_phase(PH_WA_A, d.sda_in);
            end
            default: ;
         endcase
         if (st_phase != PH_IDLE) kind_seen[kind]++;
      end else if (st_phase == PH_WA_POLL) begin
         i2c_poll_sda(d.sda_in);
      end else if (st_delay > 10'd1) begin
         st_delay = st_delay - 10'd1;
      end else begin
         i2c_advance_phase(d.sda_in);
      end
      r            = '0;
      r.scl        = st_scl;
      r.sda_out    = st_sda;
      r.sda_oe     = st_oe;
      r.busy_res   = (st_phase != PH_IDLE);
      r.done_res   = st_done;
      r.rx_byte    = st_rx;
      r.ack_failed = st_fail;
      return r;
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   // results first (they trail their items), then configuration, then the new item
   always @(posedge clock) begin : monitor
      rsp_data_type want, got;
      req_fired = 1'b0;
      if (reset) begin
         i2c_reset_state();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (pin_expect_q.size() == 0) begin
               $error("result arrived with no item outstanding");
               fail_count++;
            end else begin
               want = pin_expect_q.pop_front();
               got  = rsp_tdata;
               check_field("scl", 8'(want.scl), 8'(got.scl));
               check_field("sda_out", 8'(want.sda_out), 8'(got.sda_out));
               check_field("sda_oe", 8'(want.sda_oe), 8'(got.sda_oe));
               check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
               check_field("done_res", 8'(want.done_res), 8'(got.done_res));
               check_field("rx_byte", want.rx_byte, got.rx_byte);
               check_field("ack_failed", 8'(want.ack_failed), 8'(got.ack_failed));
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_TICKS_PER_US) cfg_tpu = csr_wdata;
            else cfg_limit = csr_wdata;
         end
         if (req_tvalid && req_tready) begin
            pin_expect_q.push_back(i2c_tick(req_tuser, req_tdata));
            items_sent++;
            req_fired = 1'b1;
            -> tick_taken;
         end
      end
   end

   // sender: bursts of random length with random gaps
   int burst_left = 0;
   int gap_left = 0;

   always @(negedge clock) begin : driver
      req_tick_type cur;
      if (!reset) begin
         if (req_tvalid && !req_fired) begin
            // item still on offer
         end else if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (tick_q.size() > 0) begin
            cur = tick_q.pop_front();
            req_tuser  <= cur.kind;
            req_tdata  <= cur.data;
            req_tvalid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 40);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: changing stall pattern plus one long hold-off
   int          hold_left = 0;
   bit          long_hold_done = 1'b0;
   int          rx_mode = 0;
   int          mode_left = 0;
   logic [1:0]  rx_phase = '0;

   always @(negedge clock) begin
      rx_phase <= rx_phase + 2'd1;
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!long_hold_done && results_seen >= 200) begin
         long_hold_done = 1'b1;
         hold_left = 300;
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            rx_mode   = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 120);
         end else begin
            mode_left--;
         end
         case (rx_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom);
            default: rsp_tready <= (rx_phase == 2'd0);
         endcase
      end
   end

   task automatic put_tick(logic [2:0] kind, logic [7:0] data_v, logic ack, logic sda);
      req_tick_type t;
      t.kind           = kind;
      t.data.pad       = '0;
      t.data.sda_in    = sda;
      t.data.send_ack  = ack;
      t.data.tx_byte   = data_v;
      tick_q.push_back(t);
      @(tick_taken);
   endtask

   task automatic put_idle();
      logic [2:0] codes [3];
      codes = '{REQ_NONE, REQ_SPARE_A, REQ_SPARE_B};
      put_tick(codes[$urandom_range(0, 2)], 8'($urandom), 1'($urandom), 1'($urandom));
   endtask

   function automatic logic plan_sda(sda_plan_type plan, int hi, int n);
      case (plan)
         SDA_LOW:      return 1'b0;
         SDA_HIGH:     return 1'b1;
         SDA_LATE_LOW: return (n < hi);
         default:      return 1'($urandom);
      endcase
   endfunction

   // issue one command, then keep ticking with busy noise until it finishes
   task automatic run_command(logic [2:0] kind, logic [7:0] data_v, logic ack,
                              sda_plan_type plan, int hi);
      int n;
      n = 0;
      cmds_issued++;
      put_tick(kind, data_v, ack, plan_sda(plan, hi, n));
      while (st_phase != PH_IDLE) begin
         n++;
         put_tick(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom),
                  plan_sda(plan, hi, n));
      end
   endtask

   function automatic sda_plan_type read_plan();
      return sda_plan_type'($urandom_range(0, 2));
   endfunction

   // first poll lands on tick 2*hold, timeout when sda stays high past the limit
   task automatic run_wait_ack();
      int base;
      int r;
      base = 2 * ((cfg_tpu == 8'd0) ? 1 : int'(cfg_tpu));
      r    = $urandom_range(0, 9);
      if (r < 7)
         run_command(REQ_WAIT_ACK, 8'($urandom), 1'($urandom), SDA_LATE_LOW,
                     $urandom_range(0, base + 2));
      else if (r < 9)
         run_command(REQ_WAIT_ACK, 8'($urandom), 1'($urandom), SDA_LATE_LOW,
                     base + int'(cfg_limit) - 1 + $urandom_range(0, 3));
      else
         run_command(REQ_WAIT_ACK, 8'($urandom), 1'($urandom), SDA_HIGH, 0);
   endtask

   task automatic run_transfer();
      int nbytes;
      bit reading;
      nbytes  = $urandom_range(1, 2);
      reading = 1'($urandom);
      run_command(REQ_START, 8'($urandom), 1'($urandom), SDA_RANDOM, 0);
      run_command(REQ_WRITE, {7'($urandom), reading}, 1'($urandom), SDA_RANDOM, 0);
      run_wait_ack();
      for (int i = 0; i < nbytes && !st_fail; i++) begin
         if (reading) begin
            run_command(REQ_READ, 8'($urandom), (i < nbytes - 1), read_plan(), 0);
         end else begin
            run_command(REQ_WRITE, 8'($urandom), 1'($urandom), SDA_RANDOM, 0);
            run_wait_ack();
         end
      end
      // on an acknowledge timeout the engine has already sent the stop
      if (!st_fail) run_command(REQ_STOP, 8'($urandom), 1'($urandom), SDA_RANDOM, 0);
   endtask

   task automatic run_single();
      logic [2:0] kind;
      kind = 3'($urandom_range(1, 5));
      if (kind == REQ_WAIT_ACK) run_wait_ack();
      else run_command(kind, 8'($urandom), 1'($urandom), read_plan(), 0);
   endtask

   task automatic csr_write(csr_index_type idx, logic [7:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      int unsigned tpu_set [8];
      int unsigned lim_set [8];
      int unsigned target;
      int          edge_hi;
      tpu_set = '{0, 1, 2, 0, 1, 2, 0, 0};
      lim_set = '{0, 1, 5, 3, 0, 2, 0, 0};
      tpu_set[6] = $urandom_range(0, 2);
      lim_set[6] = $urandom_range(0, 12);
      tpu_set[7] = $urandom_range(0, 2);
      lim_set[7] = $urandom_range(0, 12);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: spare codes and one start at the default hold
      put_tick(REQ_NONE, 8'($urandom), 1'($urandom), 1'($urandom));
      put_tick(REQ_SPARE_A, 8'($urandom), 1'($urandom), 1'($urandom));
      put_tick(REQ_SPARE_B, 8'($urandom), 1'($urandom), 1'($urandom));
      run_command(REQ_START, 8'($urandom), 1'b0, SDA_RANDOM, 0);

      // directed part at zero hold and a short acknowledge limit
      while (pin_expect_q.size() != 0) @(posedge clock);
      csr_write(CSR_TICKS_PER_US, 8'd0);
      csr_write(CSR_ACK_POLL_LIMIT, 8'd2);
      run_command(REQ_WRITE, 8'h00, 1'b1, SDA_RANDOM, 0);
      run_command(REQ_WRITE, 8'hFF, 1'b0, SDA_RANDOM, 0);
      run_command(REQ_WRITE, 8'hA5, 1'b1, SDA_RANDOM, 0);
      run_command(REQ_WAIT_ACK, 8'($urandom), 1'b0, SDA_LOW, 0);
      run_command(REQ_WAIT_ACK, 8'($urandom), 1'b1, SDA_HIGH, 0);
      run_command(REQ_START, 8'($urandom), 1'b0, SDA_RANDOM, 0);
      run_command(REQ_READ, 8'h00, 1'b1, SDA_HIGH, 0);
      run_command(REQ_READ, 8'hFF, 1'b0, SDA_LOW, 0);
      run_command(REQ_READ, 8'($urandom), 1'b1, SDA_RANDOM, 0);
      edge_hi = 2 * ((cfg_tpu == 8'd0) ? 1 : int'(cfg_tpu)) + int'(cfg_limit);
      run_command(REQ_WAIT_ACK, 8'($urandom), 1'b0, SDA_LATE_LOW, edge_hi);
      run_command(REQ_WAIT_ACK, 8'($urandom), 1'b1, SDA_LATE_LOW, edge_hi + 1);
      run_command(REQ_STOP, 8'($urandom), 1'b0, SDA_RANDOM, 0);
      run_command(REQ_STOP, 8'($urandom), 1'b1, SDA_RANDOM, 0);

      // random part, one short block of traffic per register setting
      for (int s = 0; s < 8; s++) begin
         while (pin_expect_q.size() != 0) @(posedge clock);
         csr_write(CSR_TICKS_PER_US, 8'(tpu_set[s]));
         csr_write(CSR_ACK_POLL_LIMIT, 8'(lim_set[s]));
         target = items_sent + 20;
         while (items_sent < target) begin
            if ($urandom_range(0, 3) == 0) run_transfer();
            else run_single();
            repeat ($urandom_range(0, 2)) put_idle();
         end
      end

      while (pin_expect_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("covered %0d commands (start %0d, stop %0d, write %0d, read %0d, wait ack %0d)",
               cmds_issued, kind_seen[REQ_START], kind_seen[REQ_STOP], kind_seen[REQ_WRITE],
               kind_seen[REQ_READ], kind_seen[REQ_WAIT_ACK]);
      $display("%0d ticks checked under 10 register settings, %0d acknowledge timeouts",
               results_seen, ack_timeouts);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #(50_000_000);
      $display("run stopped by the watchdog");
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

[filelist.f]
+incdir+sv
sv/i2cm_pkg.sv
sv/i2cm_csr.sv
sv/i2cm_seq.sv
sv/i2cm_out_reg.sv
sv/i2c_master_byte_engine.sv
tb/sv/tb_i2c_master_byte_engine.sv
